@@ hdl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, opcodes, status codes, pipeline types and saturation helper
// for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int WORD_W         = 32;
   localparam int OP_W           = 4;
   localparam int PROD_W         = 64;
   localparam int SUM_W          = 65;
   localparam int WIDE_W         = 66;
   localparam int DIR_W          = 34;
   localparam int QUO_W          = 33;
   localparam int SQRT_STEPS     = 32;
   localparam int STATUS_W       = 2;
   localparam int KIND_W         = 2;
   localparam int DEF_DATA_WIDTH = 32;
   localparam int DEF_FRAC_BITS  = 16;

   localparam logic [OP_W-1:0] OP_ADD     = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB     = 4'd1;
   localparam logic [OP_W-1:0] OP_ADD_RE  = 4'd2;
   localparam logic [OP_W-1:0] OP_SUB_RE  = 4'd3;
   localparam logic [OP_W-1:0] OP_MUL     = 4'd4;
   localparam logic [OP_W-1:0] OP_SCALE   = 4'd5;
   localparam logic [OP_W-1:0] OP_DIV     = 4'd6;
   localparam logic [OP_W-1:0] OP_DIV_RE  = 4'd7;
   localparam logic [OP_W-1:0] OP_EQ      = 4'd8;
   localparam logic [OP_W-1:0] OP_CONJ    = 4'd9;
   localparam logic [OP_W-1:0] OP_MAG     = 4'd10;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT      = 2'd2;

   localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DIV    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SQRT   = 2'd2;

   typedef struct packed {
      logic                     valid;
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] a_re;
      logic signed [WORD_W-1:0] a_im;
      logic signed [WORD_W-1:0] b_re;
      logic signed [WORD_W-1:0] b_im;
   } cmd_type;

   typedef struct packed {
      logic                    valid;
      logic [KIND_W-1:0]       kind;
      logic                    trunc;
      logic                    flip;
      logic                    dz;
      logic                    eq;
      logic signed [DIR_W-1:0] dir_re;
      logic signed [DIR_W-1:0] dir_im;
      logic signed [SUM_W-1:0] re_sum;
      logic signed [SUM_W-1:0] im_sum;
      logic [PROD_W-1:0]       sq;
   } sum_type;

   typedef struct packed {
      logic                     valid;
      logic [KIND_W-1:0]        kind;
      logic                     dz;
      logic                     eq;
      logic signed [WIDE_W-1:0] dir_re;
      logic signed [WIDE_W-1:0] dir_im;
      logic [PROD_W-1:0]        den;
      logic [PROD_W-1:0]        re_rem;
      logic [QUO_W-1:0]         re_bits;
      logic                     re_ovf;
      logic                     re_neg;
      logic [PROD_W-1:0]        im_rem;
      logic [QUO_W-1:0]         im_bits;
      logic                     im_ovf;
      logic                     im_neg;
      logic [PROD_W-1:0]        sq_n;
      logic [PROD_W-1:0]        sq_r;
   } iter_type;

   typedef struct packed {
      logic [WORD_W-1:0] val;
      logic              sat;
   } clamp_type;

   function automatic clamp_type sat_clamp(input logic signed [WIDE_W-1:0] v,
                                           input int sat_w);
      logic signed [WIDE_W-1:0] one;
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      clamp_type r;
      one   = WIDE_W'(1);
      hi    = (one <<< (sat_w - 1)) - one;
      lo    = -(one <<< (sat_w - 1));
      r.val = v[WORD_W-1:0];
      r.sat = 1'b0;
      if (v > hi) begin
         r.val = hi[WORD_W-1:0];
         r.sat = 1'b1;
      end else if (v < lo) begin
         r.val = lo[WORD_W-1:0];
         r.sat = 1'b1;
      end
      return r;
   endfunction

endpackage

@@ hdl/cau_mult.sv @@
// ----------------------------------------------------------------------------
// cau_mult
// Request register, partial products and product sums (three stages).
// ----------------------------------------------------------------------------
module cau_mult import cau_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [OP_W-1:0]          in_op,
   input  logic signed [WORD_W-1:0] in_a_re,
   input  logic signed [WORD_W-1:0] in_a_im,
   input  logic signed [WORD_W-1:0] in_b_re,
   input  logic signed [WORD_W-1:0] in_b_im,
   output sum_type                  sum_out
);

   typedef struct packed {
      logic                     valid;
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] a_re;
      logic signed [WORD_W-1:0] a_im;
      logic signed [WORD_W-1:0] b_re;
      logic signed [WORD_W-1:0] b_im;
      logic signed [PROD_W-1:0] m_ac;
      logic signed [PROD_W-1:0] m_bd;
      logic signed [PROD_W-1:0] m_ad;
      logic signed [PROD_W-1:0] m_bc;
      logic signed [PROD_W-1:0] m_x;
      logic signed [PROD_W-1:0] m_y;
   } prod_type;

   cmd_type  cmd_ff, cmd_in;
   prod_type prod_ff, prod_in;
   sum_type  sum_ff, sum_in;

   logic signed [WORD_W-1:0] sel_x;
   logic signed [WORD_W-1:0] sel_y;
   logic signed [WORD_W:0]   c_ext;
   logic signed [WORD_W:0]   c_abs;
   logic signed [DIR_W-1:0]  a_x, b_x, c_x, d_x;

   always_comb begin
      cmd_in.valid = in_valid;
      cmd_in.op    = in_op;
      cmd_in.a_re  = in_a_re;
      cmd_in.a_im  = in_a_im;
      cmd_in.b_re  = in_b_re;
      cmd_in.b_im  = in_b_im;
   end

   always_comb begin
      sel_x        = (cmd_ff.op == OP_MAG) ? cmd_ff.a_re : cmd_ff.b_re;
      sel_y        = (cmd_ff.op == OP_MAG) ? cmd_ff.a_im : cmd_ff.b_im;
      prod_in.valid = cmd_ff.valid;
      prod_in.op    = cmd_ff.op;
      prod_in.a_re  = cmd_ff.a_re;
      prod_in.a_im  = cmd_ff.a_im;
      prod_in.b_re  = cmd_ff.b_re;
      prod_in.b_im  = cmd_ff.b_im;
      prod_in.m_ac  = cmd_ff.a_re * cmd_ff.b_re;
      prod_in.m_bd  = cmd_ff.a_im * cmd_ff.b_im;
      prod_in.m_ad  = cmd_ff.a_re * cmd_ff.b_im;
      prod_in.m_bc  = cmd_ff.a_im * cmd_ff.b_re;
      prod_in.m_x   = sel_x * sel_x;
      prod_in.m_y   = sel_y * sel_y;
   end

   always_comb begin
      a_x   = DIR_W'(prod_ff.a_re);
      b_x   = DIR_W'(prod_ff.a_im);
      c_x   = DIR_W'(prod_ff.b_re);
      d_x   = DIR_W'(prod_ff.b_im);
      c_ext = (WORD_W+1)'(prod_ff.b_re);
      c_abs = c_ext[WORD_W] ? -c_ext : c_ext;

      sum_in.valid  = prod_ff.valid;
      sum_in.kind   = KIND_DIRECT;
      sum_in.trunc  = 1'b0;
      sum_in.flip   = 1'b0;
      sum_in.dz     = 1'b0;
      sum_in.eq     = 1'b0;
      sum_in.dir_re = '0;
      sum_in.dir_im = '0;
      sum_in.re_sum = '0;
      sum_in.im_sum = '0;
      sum_in.sq     = PROD_W'($unsigned(prod_ff.m_x)) + PROD_W'($unsigned(prod_ff.m_y));

      unique case (prod_ff.op)
         OP_ADD: begin
            sum_in.dir_re = a_x + c_x;
            sum_in.dir_im = b_x + d_x;
         end
         OP_SUB: begin
            sum_in.dir_re = a_x - c_x;
            sum_in.dir_im = b_x - d_x;
         end
         OP_ADD_RE: begin
            sum_in.dir_re = a_x + c_x;
            sum_in.dir_im = b_x;
         end
         OP_SUB_RE: begin
            sum_in.dir_re = a_x - c_x;
            sum_in.dir_im = b_x;
         end
         OP_MUL: begin
            sum_in.trunc  = 1'b1;
            sum_in.re_sum = SUM_W'(prod_ff.m_ac) - SUM_W'(prod_ff.m_bd);
            sum_in.im_sum = SUM_W'(prod_ff.m_ad) + SUM_W'(prod_ff.m_bc);
         end
         OP_SCALE: begin
            sum_in.trunc  = 1'b1;
            sum_in.re_sum = SUM_W'(prod_ff.m_ac);
            sum_in.im_sum = SUM_W'(prod_ff.m_bc);
         end
         OP_DIV: begin
            sum_in.dz     = (prod_ff.b_re == '0) && (prod_ff.b_im == '0);
            sum_in.kind   = sum_in.dz ? KIND_DIRECT : KIND_DIV;
            sum_in.re_sum = SUM_W'(prod_ff.m_ac) + SUM_W'(prod_ff.m_bd);
            sum_in.im_sum = SUM_W'(prod_ff.m_bc) - SUM_W'(prod_ff.m_ad);
         end
         OP_DIV_RE: begin
            sum_in.dz     = (prod_ff.b_re == '0);
            sum_in.kind   = sum_in.dz ? KIND_DIRECT : KIND_DIV;
            sum_in.flip   = prod_ff.b_re[WORD_W-1];
            sum_in.re_sum = SUM_W'(prod_ff.a_re);
            sum_in.im_sum = SUM_W'(prod_ff.a_im);
            sum_in.sq     = PROD_W'($unsigned(c_abs));
         end
         OP_EQ: begin
            sum_in.eq = (prod_ff.a_re == prod_ff.b_re) && (prod_ff.a_im == prod_ff.b_im);
         end
         OP_CONJ: begin
            sum_in.dir_re = a_x;
            sum_in.dir_im = -b_x;
         end
         OP_MAG: begin
            sum_in.kind = KIND_SQRT;
         end
         default: begin
            sum_in.kind = KIND_DIRECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff.valid  <= 1'b0;
         prod_ff.valid <= 1'b0;
         sum_ff.valid  <= 1'b0;
      end else begin
         cmd_ff  <= cmd_in;
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum_out = sum_ff;

endmodule

@@ hdl/cau_prep.sv @@
// ----------------------------------------------------------------------------
// cau_prep
// Fixed-point truncation, operand magnitudes, quotient range check and
// divider / square root seeding (two stages).
// ----------------------------------------------------------------------------
module cau_prep import cau_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic     clock,
   input  logic     reset,
   input  sum_type  sum_in,
   output iter_type iter_out
);

   localparam int XW = PROD_W + FRAC_BITS;
   localparam int HW = XW - QUO_W;
   localparam int CW = (HW > PROD_W) ? HW : PROD_W;
   localparam logic signed [WIDE_W-1:0] BIAS = (WIDE_W'(1) << FRAC_BITS) - WIDE_W'(1);

   typedef struct packed {
      logic                     valid;
      logic [KIND_W-1:0]        kind;
      logic                     dz;
      logic                     eq;
      logic signed [WIDE_W-1:0] dir_re;
      logic signed [WIDE_W-1:0] dir_im;
      logic [PROD_W-1:0]        re_num;
      logic                     re_neg;
      logic [PROD_W-1:0]        im_num;
      logic                     im_neg;
      logic [PROD_W-1:0]        den;
   } div_type;

   div_type  div_ff, div_in;
   iter_type iter_ff, iter_in;

   logic signed [WIDE_W-1:0] t_re, t_im;
   logic signed [SUM_W-1:0]  n_re, n_im;
   logic [XW-1:0]            x_re, x_im;
   logic [CW-1:0]            h_re, h_im;

   always_comb begin
      t_re = WIDE_W'(sum_in.re_sum) + (sum_in.re_sum[SUM_W-1] ? BIAS : '0);
      t_im = WIDE_W'(sum_in.im_sum) + (sum_in.im_sum[SUM_W-1] ? BIAS : '0);
      n_re = sum_in.re_sum[SUM_W-1] ? -sum_in.re_sum : sum_in.re_sum;
      n_im = sum_in.im_sum[SUM_W-1] ? -sum_in.im_sum : sum_in.im_sum;

      div_in.valid  = sum_in.valid;
      div_in.kind   = sum_in.kind;
      div_in.dz     = sum_in.dz;
      div_in.eq     = sum_in.eq;
      div_in.dir_re = sum_in.trunc ? (t_re >>> FRAC_BITS) : WIDE_W'(sum_in.dir_re);
      div_in.dir_im = sum_in.trunc ? (t_im >>> FRAC_BITS) : WIDE_W'(sum_in.dir_im);
      div_in.re_num = n_re[PROD_W-1:0];
      div_in.im_num = n_im[PROD_W-1:0];
      div_in.re_neg = sum_in.re_sum[SUM_W-1] ^ sum_in.flip;
      div_in.im_neg = sum_in.im_sum[SUM_W-1] ^ sum_in.flip;
      div_in.den    = sum_in.sq;
   end

   always_comb begin
      x_re = {div_ff.re_num, {FRAC_BITS{1'b0}}};
      x_im = {div_ff.im_num, {FRAC_BITS{1'b0}}};
      h_re = CW'(x_re >> QUO_W);
      h_im = CW'(x_im >> QUO_W);

      iter_in.valid   = div_ff.valid;
      iter_in.kind    = div_ff.kind;
      iter_in.dz      = div_ff.dz;
      iter_in.eq      = div_ff.eq;
      iter_in.dir_re  = div_ff.dir_re;
      iter_in.dir_im  = div_ff.dir_im;
      iter_in.den     = div_ff.den;
      iter_in.re_rem  = h_re[PROD_W-1:0];
      iter_in.re_bits = x_re[QUO_W-1:0];
      iter_in.re_ovf  = h_re >= CW'(div_ff.den);
      iter_in.re_neg  = div_ff.re_neg;
      iter_in.im_rem  = h_im[PROD_W-1:0];
      iter_in.im_bits = x_im[QUO_W-1:0];
      iter_in.im_ovf  = h_im >= CW'(div_ff.den);
      iter_in.im_neg  = div_ff.im_neg;
      iter_in.sq_n    = div_ff.den;
      iter_in.sq_r    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid  <= 1'b0;
         iter_ff.valid <= 1'b0;
      end else begin
         div_ff  <= div_in;
         iter_ff <= iter_in;
      end
   end

   assign iter_out = iter_ff;

endmodule

@@ hdl/cau_step.sv @@
// ----------------------------------------------------------------------------
// cau_step
// One pipeline stage: one restoring-division step on both lanes and, while
// STEP is below SQRT_STEPS, one bitwise square root step.
// ----------------------------------------------------------------------------
module cau_step import cau_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  iter_type step_in,
   output iter_type step_out
);

   iter_type step_ff, step_in_nx;

   logic [PROD_W:0] r2_re, r2_im, df_re, df_im;
   logic            ge_re, ge_im;
   logic [PROD_W-1:0] sq_n_nx, sq_r_nx;

   always_comb begin
      r2_re = {step_in.re_rem, step_in.re_bits[QUO_W-1]};
      r2_im = {step_in.im_rem, step_in.im_bits[QUO_W-1]};
      ge_re = r2_re >= {1'b0, step_in.den};
      ge_im = r2_im >= {1'b0, step_in.den};
      df_re = r2_re - {1'b0, step_in.den};
      df_im = r2_im - {1'b0, step_in.den};
   end

   if (STEP < SQRT_STEPS) begin : g_sqrt
      localparam logic [PROD_W-1:0] BIT = PROD_W'(1) << (PROD_W - 2 - 2 * STEP);
      logic [PROD_W-1:0] trial;
      always_comb begin
         trial = step_in.sq_r + BIT;
         if (step_in.sq_n >= trial) begin
            sq_n_nx = step_in.sq_n - trial;
            sq_r_nx = (step_in.sq_r >> 1) + BIT;
         end else begin
            sq_n_nx = step_in.sq_n;
            sq_r_nx = step_in.sq_r >> 1;
         end
      end
   end else begin : g_hold
      always_comb begin
         sq_n_nx = step_in.sq_n;
         sq_r_nx = step_in.sq_r;
      end
   end

   always_comb begin
      step_in_nx         = step_in;
      step_in_nx.re_rem  = ge_re ? df_re[PROD_W-1:0] : r2_re[PROD_W-1:0];
      step_in_nx.im_rem  = ge_im ? df_im[PROD_W-1:0] : r2_im[PROD_W-1:0];
      step_in_nx.re_bits = {step_in.re_bits[QUO_W-2:0], ge_re};
      step_in_nx.im_bits = {step_in.im_bits[QUO_W-2:0], ge_im};
      step_in_nx.sq_n    = sq_n_nx;
      step_in_nx.sq_r    = sq_r_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else begin
         step_ff <= step_in_nx;
      end
   end

   assign step_out = step_ff;

endmodule

@@ hdl/cau_final.sv @@
// ----------------------------------------------------------------------------
// cau_final
// Result select, saturation, status and the response register.
// ----------------------------------------------------------------------------
module cau_final import cau_pkg::*; #(
   parameter int SAT_W = DEF_DATA_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  iter_type                 fin_in,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_res_re,
   output logic signed [WORD_W-1:0] rsp_res_im,
   output logic                     rsp_is_equal,
   output logic [STATUS_W-1:0]      rsp_status
);

   localparam logic signed [WIDE_W-1:0] OVF_MAG = WIDE_W'(1) << QUO_W;
   localparam logic [WORD_W-1:0] LIM_HI = WORD_W'((PROD_W'(1) << (SAT_W - 1)) - PROD_W'(1));
   localparam logic [WORD_W-1:0] LIM_LO = ~LIM_HI;

   logic signed [WIDE_W-1:0] q_re, q_im, v_re, v_im;
   clamp_type                c_re, c_im;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]        rsp_res_re_ff, rsp_res_re_in;
   logic [WORD_W-1:0]        rsp_res_im_ff, rsp_res_im_in;
   logic                     rsp_is_equal_ff, rsp_is_equal_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   always_comb begin
      q_re = fin_in.re_ovf ? OVF_MAG : WIDE_W'(fin_in.re_bits);
      q_im = fin_in.im_ovf ? OVF_MAG : WIDE_W'(fin_in.im_bits);
      case (fin_in.kind)
         KIND_DIV: begin
            v_re = fin_in.re_neg ? -q_re : q_re;
            v_im = fin_in.im_neg ? -q_im : q_im;
         end
         KIND_SQRT: begin
            v_re = WIDE_W'(fin_in.sq_r);
            v_im = '0;
         end
         default: begin
            v_re = fin_in.dir_re;
            v_im = fin_in.dir_im;
         end
      endcase
      c_re = sat_clamp(v_re, SAT_W);
      c_im = sat_clamp(v_im, SAT_W);

      rsp_valid_in    = fin_in.valid;
      rsp_res_re_in   = c_re.val;
      rsp_res_im_in   = c_im.val;
      rsp_is_equal_in = fin_in.eq;
      if (fin_in.dz) begin
         rsp_status_in = ST_DIV_ZERO;
      end else if (c_re.sat || c_im.sat) begin
         rsp_status_in = ST_SAT;
      end else begin
         rsp_status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_re_ff   <= rsp_res_re_in;
      rsp_res_im_ff   <= rsp_res_im_in;
      rsp_is_equal_ff <= rsp_is_equal_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_re   = rsp_res_re_ff;
   assign rsp_res_im   = rsp_res_im_ff;
   assign rsp_is_equal = rsp_is_equal_ff;
   assign rsp_status   = rsp_status_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_DIV_ZERO |->
         rsp_res_re_ff == '0 && rsp_res_im_ff == '0)
      else $error("divide by zero with nonzero result");

   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_is_equal_ff |->
         rsp_status_ff == ST_OK && rsp_res_re_ff == '0 && rsp_res_im_ff == '0)
      else $error("compare response carries data or status");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_SAT |->
         rsp_res_re_ff == LIM_HI || rsp_res_re_ff == LIM_LO ||
         rsp_res_im_ff == LIM_HI || rsp_res_im_ff == LIM_LO)
      else $error("saturation status without a clamped part");

endmodule

@@ hdl/complex_arith_unit_core.sv @@
// ----------------------------------------------------------------------------
// complex_arith_unit_core
// Pipelined signed fixed-point complex arithmetic unit.
// ----------------------------------------------------------------------------
// A request (req_type, req_a_*, req_b_*) is taken on a rising edge with start
// high and busy low. busy is high in reset and until the first edge after
// it ends; from then on a request may be issued in every cycle.
// Each request gives one response: rsp_valid is high for exactly one cycle,
// after the request has passed 39 register stages, with rsp_res_re,
// rsp_res_im, rsp_is_equal and rsp_status.
// Responses leave in request order.
// Throughput is one request per cycle. The pipeline is the 33-stage
// restoring divider (one quotient bit per stage, both parts in parallel),
// which the 32-step square root for magnitude shares stage for stage, plus
// three multiply stages, two seeding stages and the response register.
// The receiver cannot hold responses off, so nothing in the pipe ever waits.
// Reset is synchronous and clears all valid bits; requests in flight are
// dropped.
// ----------------------------------------------------------------------------
module complex_arith_unit_core import cau_pkg::*; #(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_type,
   input  logic signed [WORD_W-1:0] req_a_re,
   input  logic signed [WORD_W-1:0] req_a_im,
   input  logic signed [WORD_W-1:0] req_b_re,
   input  logic signed [WORD_W-1:0] req_b_im,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_res_re,
   output logic signed [WORD_W-1:0] rsp_res_im,
   output logic                     rsp_is_equal,
   output logic [STATUS_W-1:0]      rsp_status
);

   localparam int SAT_W = (DATA_WIDTH > WORD_W) ? WORD_W : DATA_WIDTH;

   logic     busy_ff, busy_in;
   logic     accept;
   sum_type  sum_bus;
   iter_type iter_pipe [QUO_W+1];

   assign busy_in = 1'b0;
   assign busy    = busy_ff;
   assign accept  = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
      end
   end

   cau_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_op    (req_type),
      .in_a_re  (req_a_re),
      .in_a_im  (req_a_im),
      .in_b_re  (req_b_re),
      .in_b_im  (req_b_im),
      .sum_out  (sum_bus)
   );

   cau_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .sum_in   (sum_bus),
      .iter_out (iter_pipe[0])
   );

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      cau_step #(
         .STEP (i)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .step_in  (iter_pipe[i]),
         .step_out (iter_pipe[i+1])
      );
   end

   cau_final #(
      .SAT_W (SAT_W)
   ) u_final (
      .clock        (clock),
      .reset        (reset),
      .fin_in       (iter_pipe[QUO_W]),
      .rsp_valid    (rsp_valid),
      .rsp_res_re   (rsp_res_re),
      .rsp_res_im   (rsp_res_im),
      .rsp_is_equal (rsp_is_equal),
      .rsp_status   (rsp_status)
   );

endmodule
